[hdl/crd_pkg.sv]
// ----------------------------------------------------------------------------
// crd_pkg: shared types and constants of the drive state and line cross detector
// Transaction payloads, drive modes, register indexes and the group of
// signals that passes between the blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package crd_pkg;

  localparam int SAMPLE_BITS = 12;  // width of one infrared sample
  localparam int CFG_CNT_W   = 16;  // width of hold_ticks and debounce_ticks
  localparam int NUM_LANES   = 3;   // left, middle, right
  localparam int PADDR_W     = 4;   // four 32-bit registers

  // Button bit positions inside the two-bit button vector
  localparam int BTN_A = 0;
  localparam int BTN_B = 1;

  // Cross patterns that force a brake
  localparam logic [NUM_LANES-1:0] PAT_ALL   = 3'b111;
  localparam logic [NUM_LANES-1:0] PAT_OUTER = 3'b101;

  // Register reset values
  localparam logic [SAMPLE_BITS-1:0] RST_IR_THRESHOLD   = 12'd2048;
  localparam logic [CFG_CNT_W-1:0]   RST_HOLD_TICKS     = 16'd10;
  localparam logic [CFG_CNT_W-1:0]   RST_DEBOUNCE_TICKS = 16'd10;
  localparam logic                   RST_IR_ENABLE      = 1'b1;

  typedef enum logic [1:0] {
    MODE_STAY  = 2'd0,
    MODE_START = 2'd1,
    MODE_RIDE  = 2'd2,
    MODE_BRAKE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_IR_THRESHOLD   = 2'd0,
    REG_HOLD_TICKS     = 2'd1,
    REG_DEBOUNCE_TICKS = 2'd2,
    REG_IR_ENABLE      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                   button_a;
    logic                   button_b;
    logic [SAMPLE_BITS-1:0] ir_left;
    logic [SAMPLE_BITS-1:0] ir_middle;
    logic [SAMPLE_BITS-1:0] ir_right;
    logic                   start_done;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           drive_state;
    logic [NUM_LANES-1:0] cross_bits;
    logic                 brake_event;
    logic                 tracker_reset;
    logic                 regulator_reset;
  } out_item_t;

  // Button edges seen on a sampling tick
  typedef struct packed {
    logic trk;
    logic reg_pulse;
  } btn_evt_t;

  // Lane control from the merging stage
  typedef struct packed {
    logic update;  // commit the lane's sensing result this tick
    logic clear;   // brake: drop the cross bit and the hold counter
  } lane_ctl_t;

endpackage : crd_pkg

`default_nettype wire

[hdl/crd_lane.sv]
// ----------------------------------------------------------------------------
// crd_lane: cross detector for one infrared sensor
// Threshold compare, cross bit and hold counter of one sensor.
// ----------------------------------------------------------------------------
`default_nettype none

module crd_lane #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire logic [crd_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic [crd_pkg::SAMPLE_BITS-1:0] threshold,
  input  wire logic [COUNT_WIDTH-1:0]          reload,
  input  wire crd_pkg::lane_ctl_t              ctl,
  output logic                                 seen_bit,
  output logic                                 sense_bit
);
  import crd_pkg::*;

  logic                   seen_r, seen_nxt;
  logic [COUNT_WIDTH-1:0] hold_r, hold_nxt;

  always_comb begin
    seen_nxt = seen_r;
    hold_nxt = hold_r;
    if (sample > threshold) begin
      seen_nxt = 1'b1;
      hold_nxt = reload;
    end else if (hold_r != '0) begin
      hold_nxt = hold_r - COUNT_WIDTH'(1);
    end else begin
      seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      hold_r <= '0;
    end else if (ctl.update) begin
      if (ctl.clear) begin
        seen_r <= 1'b0;
        hold_r <= '0;
      end else begin
        seen_r <= seen_nxt;
        hold_r <= hold_nxt;
      end
    end
  end

  assign seen_bit  = seen_r;
  assign sense_bit = seen_nxt;

endmodule : crd_lane

`default_nettype wire

[hdl/crd_button.sv]
// ----------------------------------------------------------------------------
// crd_button: button debounce window and edge detect
// Samples both buttons when the window is idle and flags rising edges.
// ----------------------------------------------------------------------------
`default_nettype none

module crd_button #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                tick,
  input  wire logic [1:0]                    buttons,
  input  wire logic [crd_pkg::CFG_CNT_W-1:0] debounce_ticks,
  output crd_pkg::btn_evt_t                  evt
);
  import crd_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > CFG_CNT_W) ? COUNT_WIDTH : CFG_CNT_W;

  logic                   busy_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [1:0]             last_r;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   window_done;

  assign cnt_inc     = cnt_r + COUNT_WIDTH'(1);
  assign window_done = CMP_W'(cnt_inc) >= CMP_W'(debounce_ticks);

  always_comb begin
    evt.trk       = !busy_r && buttons[BTN_A] && !last_r[BTN_A];
    evt.reg_pulse = !busy_r && buttons[BTN_B] && !last_r[BTN_B];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      last_r <= '0;
    end else if (tick) begin
      if (!busy_r) begin
        busy_r <= 1'b1;
        last_r <= buttons;
      end else if (window_done) begin
        busy_r <= 1'b0;
        cnt_r  <= '0;
      end else begin
        cnt_r <= cnt_inc;
      end
    end
  end

endmodule : crd_button

`default_nettype wire

[hdl/crd_merge.sv]
// ----------------------------------------------------------------------------
// crd_merge: drive mode machine and lane merge
// Combines the lane results into the brake decision and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module crd_merge (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                tick,
  input  wire crd_pkg::btn_evt_t             evt,
  input  wire                                ir_enable,
  input  wire                                start_done,
  input  wire logic [crd_pkg::NUM_LANES-1:0] sense_bits,
  input  wire logic [crd_pkg::NUM_LANES-1:0] seen_bits,
  output crd_pkg::lane_ctl_t                 ctl,
  output crd_pkg::out_item_t                 result
);
  import crd_pkg::*;

  mode_t mode_r, mode_nxt, mode_btn;
  logic  run;
  logic  brake;

  // Mode after the button B edge
  always_comb begin
    mode_btn = mode_r;
    if (evt.reg_pulse) begin
      unique case (mode_r) inside
        MODE_STAY:              mode_btn = MODE_START;
        MODE_RIDE, MODE_BRAKE:  mode_btn = MODE_STAY;
        default:                mode_btn = mode_r;
      endcase
    end
  end

  // Outputs
  always_comb begin
    run        = (mode_btn == MODE_RIDE) && ir_enable;
    brake      = run && ((sense_bits == PAT_ALL) || (sense_bits == PAT_OUTER));
    ctl.update = tick && run;
    ctl.clear  = brake;
  end

  // Next state
  always_comb begin
    mode_nxt = mode_btn;
    if (brake) begin
      mode_nxt = MODE_BRAKE;
    end else if (mode_btn == MODE_START && start_done) begin
      mode_nxt = MODE_RIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STAY;
    end else if (tick) begin
      mode_r <= mode_nxt;
    end
  end

  always_comb begin
    result.drive_state     = mode_nxt;
    result.cross_bits      = brake ? '0 : (run ? sense_bits : seen_bits);
    result.brake_event     = brake;
    result.tracker_reset   = evt.trk;
    result.regulator_reset = evt.reg_pulse;
  end

endmodule : crd_merge

`default_nettype wire

[hdl/drive_state_and_line_cross_detector.sv]
// ----------------------------------------------------------------------------
// drive_state_and_line_cross_detector: drive mode and line cross detection
// Takes one control tick per transaction and returns one result per tick:
// the drive mode, the three cross bits, and the brake, tracker-reset and
// regulator-reset pulses. A tick is accepted whenever the output register
// is free or is being emptied; each result appears in the output register
// in the cycle after its tick is accepted and is held there until taken,
// while the next tick is already accepted when the consumer takes the held
// result in the same cycle. The per-tick work is one 12-bit compare and one
// counter update in each of three sensor lanes plus the debounce counter,
// all computed combinationally, so the rate is one tick per clock unless out_ready stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_state_and_line_cross_detector #(
  parameter int COUNT_WIDTH = 16  // hold and debounce counter width, 4..32
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // tick channel
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire crd_pkg::in_item_t           in_data,
  // result channel
  output logic                             out_valid,
  input  wire                              out_ready,
  output crd_pkg::out_item_t               out_data,
  // configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire logic [crd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import crd_pkg::*;

  localparam int RELOAD_W = (COUNT_WIDTH > CFG_CNT_W) ? COUNT_WIDTH : CFG_CNT_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] ir_threshold_r;
  logic [CFG_CNT_W-1:0]   hold_ticks_r;
  logic [CFG_CNT_W-1:0]   debounce_ticks_r;
  logic                   ir_enable_r;
  logic                   cfg_wr;
  reg_idx_t               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_threshold_r   <= RST_IR_THRESHOLD;
      hold_ticks_r     <= RST_HOLD_TICKS;
      debounce_ticks_r <= RST_DEBOUNCE_TICKS;
      ir_enable_r      <= RST_IR_ENABLE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IR_THRESHOLD:   ir_threshold_r   <= pwdata[SAMPLE_BITS-1:0];
        REG_HOLD_TICKS:     hold_ticks_r     <= pwdata[CFG_CNT_W-1:0];
        REG_DEBOUNCE_TICKS: debounce_ticks_r <= pwdata[CFG_CNT_W-1:0];
        REG_IR_ENABLE:      ir_enable_r      <= pwdata[0];
        default:            ir_enable_r      <= ir_enable_r;
      endcase
    end
  end

  // Read back; registers are zero-extended to the bus
  always_comb begin
    unique case (cfg_idx)
      REG_IR_THRESHOLD:   prdata = 32'(ir_threshold_r);
      REG_HOLD_TICKS:     prdata = 32'(hold_ticks_r);
      REG_DEBOUNCE_TICKS: prdata = 32'(debounce_ticks_r);
      REG_IR_ENABLE:      prdata = 32'(ir_enable_r);
      default:            prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: a tick is accepted whenever the output register is free or is
  // being emptied in the same cycle.
  // --------------------------------------------------------------------------
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t result;
  logic      tick;

  assign in_ready = !out_valid_r || out_ready;
  assign tick     = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Button debounce and edge detect
  // --------------------------------------------------------------------------
  btn_evt_t evt;

  crd_button #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_button (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick           (tick),
    .buttons        ({in_data.button_b, in_data.button_a}),
    .debounce_ticks (debounce_ticks_r),
    .evt            (evt)
  );

  // --------------------------------------------------------------------------
  // Sensor lanes: one cross detector per sensor, all three in parallel
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] samples [NUM_LANES];
  logic [RELOAD_W-1:0]    hold_ext;
  logic [COUNT_WIDTH-1:0] reload;
  logic [NUM_LANES-1:0]   seen_bits;
  logic [NUM_LANES-1:0]   sense_bits;
  lane_ctl_t              lane_ctl;

  assign samples[0] = in_data.ir_left;
  assign samples[1] = in_data.ir_middle;
  assign samples[2] = in_data.ir_right;

  // Reload value cut or widened to the counter width
  assign hold_ext = RELOAD_W'(hold_ticks_r);
  assign reload   = hold_ext[COUNT_WIDTH-1:0];

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    crd_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .sample    (samples[g]),
      .threshold (ir_threshold_r),
      .reload    (reload),
      .ctl       (lane_ctl),
      .seen_bit  (seen_bits[g]),
      .sense_bit (sense_bits[g])
    );
  end

  // --------------------------------------------------------------------------
  // Merge: drive mode, brake decision, result item
  // --------------------------------------------------------------------------
  crd_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (tick),
    .evt        (evt),
    .ir_enable  (ir_enable_r),
    .start_done (in_data.start_done),
    .sense_bits (sense_bits),
    .seen_bits  (seen_bits),
    .ctl        (lane_ctl),
    .result     (result)
  );

  // --------------------------------------------------------------------------
  // Output register: load on accept, drop valid once taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A brake result always reports brake mode with every cross bit dropped
  a_brake_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.brake_event |->
      (out_data_r.drive_state == MODE_BRAKE) && (out_data_r.cross_bits == '0))
    else $error("brake result without brake mode or with cross bits set");

  // A brake pattern is never left standing in the lanes
  a_no_stored_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_bits != PAT_ALL) && (seen_bits != PAT_OUTER))
    else $error("lanes hold a brake pattern");

  // Every accepted tick shows up in the output register on the next cycle
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> out_valid_r)
    else $error("accepted tick produced no result");
`endif

endmodule : drive_state_and_line_cross_detector

`default_nettype wire
